### rtl/core/ssi_pkg.sv
// ssi_pkg: shared constants and the controller state type for the
// sorted set intersection block. No dependencies.
package ssi_pkg;

	localparam int VALUE_W      = 32;
	localparam int CAPACITY_DEF = 32;
	localparam int MAX_RESULTS  = 32;
	localparam int RES_W        = $clog2(MAX_RESULTS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_SCAN,
		ST_ISX_RDA,
		ST_ISX_LATCH,
		ST_ISX_SCAN,
		ST_SEL_SCAN
	} state_t;

endpackage

### rtl/core/ssi_ram.sv
// ssi_ram: generic single write port, single read port ram with registered read.
// No dependencies.
module ssi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/sorted_set_intersection.sv
// sorted_set_intersection: top level, set storage, duplicate search, intersection
// and ordered output. Depends on ssi_pkg and ssi_ram.
//
// Values are requested one at a time, each tagged for the first (func = 0) or the
// second (func = 1) set. Each set keeps at most CAPACITY distinct values; repeats
// and values past a full set are dropped. Before each append the memory of the
// chosen set is searched for a duplicate one entry per cycle through its single
// read port. A second-set request with last_of_set starts the run: every
// first-set value is looked up in the second-set memory, matches are written to a
// third memory, and each result then costs one pass over that memory to pick the
// next larger value, so results come out in ascending signed order, at most 32 of
// them, the final one with last set. An empty intersection gives one result with
// is_empty set. The next request is accepted while the final result still waits
// in the output register. No clearing pass follows reset.
module sorted_set_intersection #(
	parameter int CAPACITY = ssi_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic                              func,
	input  logic signed [ssi_pkg::VALUE_W-1:0] value,
	input  logic                              last_of_set,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic signed [ssi_pkg::VALUE_W-1:0] common_value,
	output logic                              is_empty,
	output logic                              last
);

	import ssi_pkg::*;

	localparam int AW    = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > RES_W + 1) ? CNT_W : RES_W + 1;

	state_t state_q, state_d;

	logic [CNT_W-1:0] fir_cnt_q, sec_cnt_q, com_cnt_q;
	logic [CNT_W-1:0] rd_idx_q, a_q, scan_lim, sel_cnt;
	logic             rd_vld_s1;
	logic             func_q, last_q;
	logic signed [VALUE_W-1:0] val_q;

	logic signed [VALUE_W-1:0] fir_rdata, sec_rdata, com_rdata, sel_rdata;
	logic [AW-1:0]             fir_raddr;
	logic                      fir_we, sec_we, com_we;

	logic signed [VALUE_W-1:0] best_q, prev_q;
	logic                      best_vld_q, have_prev_q;
	logic [RES_W-1:0]          e_q;

	logic out_vld_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic out_empty_q, out_last_q;

	logic issue, scan_end, hit, cand, res_last, is_last;
	logic out_load, sel_again, clear, scan_rst;

	// memories
	ssi_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_fir_ram (
		.clk   (clk),
		.we    (fir_we),
		.waddr (fir_cnt_q[AW-1:0]),
		.wdata (val_q),
		.raddr (fir_raddr),
		.rdata (fir_rdata)
	);

	ssi_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_sec_ram (
		.clk   (clk),
		.we    (sec_we),
		.waddr (sec_cnt_q[AW-1:0]),
		.wdata (val_q),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (sec_rdata)
	);

	ssi_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_com_ram (
		.clk   (clk),
		.we    (com_we),
		.waddr (com_cnt_q[AW-1:0]),
		.wdata (val_q),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (com_rdata)
	);

	assign fir_raddr = (state_q == ST_ISX_RDA) ? a_q[AW-1:0] : rd_idx_q[AW-1:0];
	assign sel_cnt   = func_q ? sec_cnt_q : fir_cnt_q;
	assign sel_rdata = func_q ? sec_rdata : fir_rdata;

	always_comb begin
		case (state_q)
			ST_INS_SCAN: scan_lim = sel_cnt;
			ST_ISX_SCAN: scan_lim = sec_cnt_q;
			ST_SEL_SCAN: scan_lim = com_cnt_q;
			default:     scan_lim = '0;
		endcase
	end

	assign issue    = (rd_idx_q != scan_lim);
	assign scan_end = !issue && !rd_vld_s1;
	assign hit      = rd_vld_s1 && (sel_rdata == val_q);
	assign cand     = (!have_prev_q || (com_rdata > prev_q)) &&
	                  (!best_vld_q || (com_rdata < best_q));
	assign is_last  = (e_q == RES_W'(MAX_RESULTS - 1)) ||
	                  ((CMP_W'(e_q) + CMP_W'(1)) == CMP_W'(com_cnt_q));
	assign res_last = !best_vld_q || is_last;

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = out_vld_q;
	assign common_value = out_value_q;
	assign is_empty     = out_empty_q;
	assign last         = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		fir_we    = 1'b0;
		sec_we    = 1'b0;
		com_we    = 1'b0;
		out_load  = 1'b0;
		sel_again = 1'b0;
		clear     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_INS_SCAN;
				end
			end
			ST_INS_SCAN: begin
				if (hit || scan_end) begin
					if (!hit && (sel_cnt != CNT_W'(CAPACITY))) begin
						sec_we = func_q;
						fir_we = !func_q;
					end
					state_d = (func_q && last_q) ? ST_ISX_RDA : ST_IDLE;
				end
			end
			ST_ISX_RDA: begin
				state_d = (a_q == fir_cnt_q) ? ST_SEL_SCAN : ST_ISX_LATCH;
			end
			ST_ISX_LATCH: begin
				state_d = ST_ISX_SCAN;
			end
			ST_ISX_SCAN: begin
				if (hit) begin
					com_we  = 1'b1;
					state_d = ST_ISX_RDA;
				end else if (scan_end) begin
					state_d = ST_ISX_RDA;
				end
			end
			ST_SEL_SCAN: begin
				if (scan_end && (!out_vld_q || !result_stall)) begin
					out_load = 1'b1;
					if (res_last) begin
						clear   = 1'b1;
						state_d = ST_IDLE;
					end else begin
						sel_again = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign scan_rst = (state_d != state_q) || sel_again;

	// counts and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fir_cnt_q <= '0;
			sec_cnt_q <= '0;
			com_cnt_q <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			a_q       <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (clear) begin
				fir_cnt_q <= '0;
				sec_cnt_q <= '0;
				com_cnt_q <= '0;
			end else begin
				if (fir_we) fir_cnt_q <= fir_cnt_q + CNT_W'(1);
				if (sec_we) sec_cnt_q <= sec_cnt_q + CNT_W'(1);
				if (com_we) com_cnt_q <= com_cnt_q + CNT_W'(1);
			end
			if (scan_rst) begin
				rd_idx_q  <= '0;
				rd_vld_s1 <= 1'b0;
			end else begin
				if (issue) rd_idx_q <= rd_idx_q + CNT_W'(1);
				rd_vld_s1 <= issue;
			end
			if (state_q == ST_INS_SCAN) begin
				a_q <= '0;
			end else if (state_q == ST_ISX_SCAN && state_d == ST_ISX_RDA) begin
				a_q <= a_q + CNT_W'(1);
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (!result_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// request capture and ordered selection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_vld_q  <= 1'b0;
			have_prev_q <= 1'b0;
			e_q         <= '0;
		end else begin
			if (scan_rst) begin
				best_vld_q <= 1'b0;
			end else if (state_q == ST_SEL_SCAN && rd_vld_s1 && cand) begin
				best_vld_q <= 1'b1;
			end
			if (state_q != ST_SEL_SCAN) begin
				have_prev_q <= 1'b0;
				e_q         <= '0;
			end else if (sel_again) begin
				have_prev_q <= 1'b1;
				e_q         <= e_q + RES_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			func_q <= func;
			val_q  <= value;
			last_q <= last_of_set;
		end else if (state_q == ST_ISX_LATCH) begin
			val_q <= fir_rdata;
		end
		if (state_q == ST_SEL_SCAN && rd_vld_s1 && cand) begin
			best_q <= com_rdata;
		end
		if (sel_again) begin
			prev_q <= best_q;
		end
		if (out_load) begin
			out_value_q <= best_vld_q ? best_q : '0;
			out_empty_q <= !best_vld_q;
			out_last_q  <= res_last;
		end
	end

endmodule

### test/sorted_set_intersection_tb.sv
// sorted_set_intersection_tb: self-checking testbench for sorted_set_intersection.
// Depends on ssi_pkg and the block's RTL; directed and random requests are checked
// against a predictor held in a small scoreboard class.
module sorted_set_intersection_tb;
	import ssi_pkg::*;

	localparam int SET_CAP         = CAPACITY_DEF;
	localparam int RANDOM_REQUESTS = 300;
	localparam int DRAIN_CYCLES    = 200;
	localparam int VAL_MAX         = 32'sh7FFF_FFFF;
	localparam int VAL_MIN         = 32'sh8000_0000;

	typedef struct {
		int   common_value;
		logic is_empty;
		logic last;
	} common_result_t;

	class intersection_scoreboard;
		int             first_set[$];
		int             second_set[$];
		common_result_t pending_results[$];
		int             errors;
		int             requests;
		int             runs;
		int             empty_runs;
		int             results_checked;

		function new();
			errors          = 0;
			requests        = 0;
			runs            = 0;
			empty_runs      = 0;
			results_checked = 0;
		endfunction

		function bit in_second(int v);
			int k;
			for (k = 0; k < second_set.size(); k++)
				if (second_set[k] == v)
					return 1'b1;
			return 1'b0;
		endfunction

		function bit in_first(int v);
			int k;
			for (k = 0; k < first_set.size(); k++)
				if (first_set[k] == v)
					return 1'b1;
			return 1'b0;
		endfunction

		// repeats and values past a full set are dropped
		function void add_value(logic to_second, int v);
			if (to_second) begin
				if (!in_second(v) && second_set.size() < SET_CAP)
					second_set.push_back(v);
			end else begin
				if (!in_first(v) && first_set.size() < SET_CAP)
					first_set.push_back(v);
			end
		endfunction

		function void note_request(logic f, int v, logic l);
			int             common[$];
			int             j;
			int             pos;
			int             n;
			common_result_t r;
			requests++;
			add_value(f, v);
			if (f && l) begin
				runs++;
				for (j = 0; j < first_set.size(); j++) begin
					if (in_second(first_set[j])) begin
						pos = 0;
						while (pos < common.size() && common[pos] < first_set[j])
							pos++;
						common.insert(pos, first_set[j]);
					end
				end
				if (common.size() == 0) begin
					empty_runs++;
					r.common_value = 0;
					r.is_empty     = 1'b1;
					r.last         = 1'b1;
					pending_results.push_back(r);
				end else begin
					n = (common.size() > MAX_RESULTS) ? MAX_RESULTS : common.size();
					for (j = 0; j < n; j++) begin
						r.common_value = common[j];
						r.is_empty     = 1'b0;
						r.last         = (j == n - 1);
						pending_results.push_back(r);
					end
				end
				first_set.delete();
				second_set.delete();
			end
		endfunction

		function void check_result(logic signed [VALUE_W-1:0] cv, logic emp, logic lst);
			common_result_t want;
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: common_value %0d is_empty %0b last %0b",
					cv, emp, lst);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			results_checked++;
			if (cv !== want.common_value) begin
				$error("common_value: expected %0d, got %0d", want.common_value, cv);
				errors++;
			end
			if (emp !== want.is_empty) begin
				$error("is_empty: expected %0b, got %0b", want.is_empty, emp);
				errors++;
			end
			if (lst !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      item_valid   = 1'b0;
	logic                      item_stall;
	logic                      func         = 1'b0;
	logic signed [VALUE_W-1:0] value        = '0;
	logic                      last_of_set  = 1'b0;
	logic                      result_valid;
	logic                      result_stall = 1'b0;
	logic signed [VALUE_W-1:0] common_value;
	logic                      is_empty;
	logic                      last;

	int                     send_idle_pct  = 0;
	int                     recv_stall_pct = 0;
	intersection_scoreboard sb;

	sorted_set_intersection uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.func         (func),
		.value        (value),
		.last_of_set  (last_of_set),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.common_value (common_value),
		.is_empty     (is_empty),
		.last         (last)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		result_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(common_value, is_empty, last);
	end

	task automatic send_request(input logic f, input int v, input logic l);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid  <= 1'b1;
		func        <= f;
		value       <= v;
		last_of_set <= l;
		do
			@(posedge clk);
		while (item_stall);
		sb.note_request(f, v, l);
	endtask

	// hold the sender off until every expected result has come
	task automatic wait_for_results();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic int pick_value(int base);
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: return VAL_MIN;
					1: return VAL_MAX;
					2: return 0;
					default: return -1;
				endcase
			end
			1, 2, 3: return $urandom;
			default: return base + $urandom_range(15);
		endcase
	endfunction

	// one pair of sets, items interleaved, closed by the compute request
	task automatic run_sets(input int n1, input int n2, input int base, input bit full);
		int   firsts[$];
		int   seconds[$];
		int   k;
		logic tag;
		for (k = 0; k < n1; k++)
			firsts.push_back(full ? base + k : pick_value(base));
		for (k = 0; k < n2; k++)
			seconds.push_back(full ? base + n2 - 1 - k : pick_value(base));
		while (firsts.size() != 0 || seconds.size() > 1) begin
			if (seconds.size() == 1 || (firsts.size() != 0 && $urandom_range(1) == 0)) begin
				tag = (firsts.size() == 1) || ($urandom_range(7) == 0);
				send_request(1'b0, firsts.pop_front(), tag);
			end else begin
				send_request(1'b1, seconds.pop_front(), 1'b0);
			end
		end
		send_request(1'b1, seconds.pop_front(), 1'b1);
	endtask

	initial begin
		int phase;
		int directed_count;
		int base;
		sb = new();
		send_idle_pct  = 38;
		recv_stall_pct = 87;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// lone compute request, first set empty
		send_request(1'b1, 7, 1'b1);
		// extremes, repeats, last marker on the first set
		send_request(1'b0, VAL_MAX, 1'b0);
		send_request(1'b0, VAL_MIN, 1'b0);
		send_request(1'b0, 0, 1'b0);
		send_request(1'b0, -1, 1'b0);
		send_request(1'b0, VAL_MAX, 1'b0);
		send_request(1'b0, 1, 1'b1);
		send_request(1'b0, 5, 1'b0);
		send_request(1'b1, -1, 1'b0);
		send_request(1'b1, VAL_MAX, 1'b0);
		send_request(1'b1, 1, 1'b0);
		send_request(1'b1, 1, 1'b0);
		send_request(1'b1, VAL_MIN, 1'b0);
		send_request(1'b1, 6, 1'b0);
		send_request(1'b1, 0, 1'b1);
		// disjoint sets
		send_request(1'b0, 100, 1'b1);
		send_request(1'b1, -100, 1'b0);
		send_request(1'b1, 200, 1'b1);
		wait_for_results();
		directed_count = sb.requests;

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 38;
					recv_stall_pct = 87;
				end
				1: begin
					send_idle_pct  = 87;
					recv_stall_pct = 38;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					// both sets overflow; the kept values share all but two of each set
					run_sets(SET_CAP + 2, SET_CAP + 2, $urandom, 1'b1);
				end
			endcase
			while (sb.requests - directed_count < (phase + 1) * RANDOM_REQUESTS / 3) begin
				base = $urandom_range(1) ? $urandom : -8;
				if ($urandom_range(15) == 0)
					run_sets(SET_CAP + 1, $urandom_range(1, SET_CAP + 1), base, 1'b1);
				else
					run_sets($urandom_range(10), $urandom_range(1, 10), base, 1'b0);
			end
			wait_for_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests in %0d intersection runs, %0d of them empty",
			sb.requests, sb.runs, sb.empty_runs);
		$display("checked %0d results under three sender and receiver idling mixes",
			sb.results_checked);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("sorted_set_intersection_tb OK");
		else
			$display("sorted_set_intersection_tb NOT OK");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout");
		$display("sorted_set_intersection_tb NOT OK");
		$finish;
	end

endmodule
